[rtl/boid_pkg.sv]
// Package with the shared types and constants of the BER object identifier decoder.
`default_nettype none

package boid_pkg;

    localparam int CNT_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 7;
    localparam int DIGIT_W  = 7;

    localparam logic [7:0] ARC_SPAN = 8'd40;
    localparam logic [DIGIT_W-1:0] DIGIT_MASK = 7'h7F;
    localparam int CONT_BIT = 7;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_CAPACITY = 2'd2
    } err_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               last;
        err_t               err;
    } result_t;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic               first;
        logic [CNT_W-1:0]   count;
        logic               ovf;
    } state_t;

endpackage

`default_nettype wire

[rtl/boid_step.sv]
// Combinational step of the decoder: next state and up to two results for one octet.
`default_nettype none

module boid_step #(
    parameter int MAX_SUBIDS = 128
) (
    input  var boid_pkg::state_t  state_cur,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    output var boid_pkg::state_t  state_nxt,
    output var boid_pkg::result_t res0,
    output var boid_pkg::result_t res1,
    output logic [1:0]            res_count
);

    localparam logic [boid_pkg::CNT_W-1:0] MAX_CNT = boid_pkg::CNT_W'(MAX_SUBIDS);

    logic [1:0]                   hi_arc;
    logic [7:0]                   lo_arc;
    logic                         ovf_new;
    logic [boid_pkg::VALUE_W-1:0] acc_new;
    logic                         emit;

    always_comb
    begin
        if (data_byte < boid_pkg::ARC_SPAN)
        begin
            hi_arc = 2'd0;
            lo_arc = data_byte;
        end
        else if (data_byte < 8'(2 * boid_pkg::ARC_SPAN))
        begin
            hi_arc = 2'd1;
            lo_arc = 8'(data_byte - boid_pkg::ARC_SPAN);
        end
        else
        begin
            hi_arc = 2'd2;
            lo_arc = 8'(data_byte - 8'(2 * boid_pkg::ARC_SPAN));
        end
    end

    assign ovf_new = state_cur.ovf
                   | (state_cur.acc[boid_pkg::VALUE_W-1 -: boid_pkg::DIGIT_W] != '0);
    assign acc_new = {state_cur.acc[boid_pkg::VALUE_W-boid_pkg::DIGIT_W-1:0],
                      data_byte[boid_pkg::DIGIT_W-1:0] & boid_pkg::DIGIT_MASK};
    assign emit    = last_byte | ~data_byte[boid_pkg::CONT_BIT];

    always_comb
    begin
        state_nxt = state_cur;
        res0      = '0;
        res1      = '0;
        res_count = 2'd0;
        if (state_cur.first)
        begin
            res0.value  = boid_pkg::VALUE_W'(hi_arc);
            res0.err    = boid_pkg::ERR_NONE;
            res1.value  = boid_pkg::VALUE_W'(lo_arc);
            res1.index  = boid_pkg::INDEX_W'(1);
            res1.last   = last_byte;
            res1.err    = boid_pkg::ERR_NONE;
            res_count   = 2'd2;
            state_nxt.acc   = '0;
            state_nxt.ovf   = 1'b0;
            state_nxt.first = last_byte;
            state_nxt.count = last_byte ? '0 : boid_pkg::CNT_W'(2);
        end
        else if (emit)
        begin
            res_count = 2'd1;
            res0.last = last_byte;
            if (state_cur.count >= MAX_CNT)
            begin
                res0.err = boid_pkg::ERR_CAPACITY;
            end
            else
            begin
                res0.value      = acc_new;
                res0.index      = state_cur.count[boid_pkg::INDEX_W-1:0];
                res0.err        = ovf_new ? boid_pkg::ERR_OVERFLOW : boid_pkg::ERR_NONE;
                state_nxt.count = boid_pkg::CNT_W'(state_cur.count + 1'b1);
            end
            state_nxt.acc = '0;
            state_nxt.ovf = 1'b0;
            if (last_byte)
            begin
                state_nxt.first = 1'b1;
                state_nxt.count = '0;
            end
        end
        else
        begin
            state_nxt.acc = acc_new;
            state_nxt.ovf = ovf_new;
        end
    end

endmodule

`default_nettype wire

[rtl/ber_oid_decoder.sv]
// Top level of the BER object identifier decoder with a two-entry result queue.
// An octet's results are registered into the queue when it is taken, then offered in order.
// Throughput: one octet per cycle; any octet waits while two results are queued, and an
// identifier's first octet, which gives two results, also waits while one is queued.
// Reset: rst_n clears the decoder state and empties the queue; no result is offered.
`default_nettype none

module ber_oid_decoder #(
    parameter int MAX_SUBIDS = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             subid_valid,
    input  wire logic        subid_stall,
    output logic [31:0]      subid_value,
    output logic [6:0]       subid_index,
    output logic             last_subid,
    output logic [1:0]       error_code
);

    boid_pkg::state_t  state_reg;
    boid_pkg::state_t  state_next;
    boid_pkg::state_t  step_state;
    boid_pkg::result_t res0;
    boid_pkg::result_t res1;
    logic [1:0]        res_count;
    boid_pkg::result_t slot_reg  [2];
    boid_pkg::result_t slot_next [2];
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic [1:0]        cnt_pop;
    logic              take;
    logic              pop;

    boid_step #(
        .MAX_SUBIDS (MAX_SUBIDS)
    ) u_step (
        .state_cur (state_reg),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .state_nxt (step_state),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    assign byte_stall = (cnt_reg == 2'd2) || ((cnt_reg == 2'd1) && state_reg.first);
    assign take       = byte_valid && !byte_stall;
    assign pop        = subid_valid && !subid_stall;
    assign cnt_pop    = cnt_reg - {1'b0, pop};
    assign state_next = take ? step_state : state_reg;

    always_comb
    begin
        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        cnt_next     = cnt_pop;
        if (take)
        begin
            cnt_next = 2'(cnt_pop + res_count);
            if (res_count == 2'd2)
            begin
                slot_next[0] = res0;
                slot_next[1] = res1;
            end
            else if (res_count == 2'd1)
            begin
                if (cnt_pop == 2'd0)
                begin
                    slot_next[0] = res0;
                end
                else
                begin
                    slot_next[1] = res0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{acc: '0, first: 1'b1, count: '0, ovf: 1'b0};
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assign subid_valid = (cnt_reg != 2'd0);
    assign subid_value = slot_reg[0].value;
    assign subid_index = slot_reg[0].index;
    assign last_subid  = slot_reg[0].last;
    assign error_code  = slot_reg[0].err;

endmodule

`default_nettype wire

[rtl/boid_checker.sv]
// Port-level assertions for the BER object identifier decoder and their binding.
`default_nettype none

module boid_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        subid_valid,
    input wire logic        subid_stall,
    input wire logic [31:0] subid_value,
    input wire logic [6:0]  subid_index,
    input wire logic        last_subid,
    input wire logic [1:0]  error_code
);

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        subid_valid && subid_stall |=> subid_valid && $stable(subid_value)
            && $stable(subid_index) && $stable(last_subid) && $stable(error_code))
        else $error("Stalled result changed or was withdrawn.");

    a_legal_error: assert property (@(posedge clk) disable iff (!rst_n)
        subid_valid |-> (error_code == boid_pkg::ERR_NONE)
            || (error_code == boid_pkg::ERR_OVERFLOW)
            || (error_code == boid_pkg::ERR_CAPACITY))
        else $error("Result carries an undefined error code.");

    a_dropped_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        subid_valid && (error_code == boid_pkg::ERR_CAPACITY)
            |-> (subid_value == 32'd0) && (subid_index == 7'd0))
        else $error("Dropped subidentifier carries a value or index.");

    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !subid_valid)
        else $error("Result offered right after reset.");

endmodule

bind ber_oid_decoder boid_checker u_boid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .subid_valid (subid_valid),
    .subid_stall (subid_stall),
    .subid_value (subid_value),
    .subid_index (subid_index),
    .last_subid  (last_subid),
    .error_code  (error_code)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for ber_oid_decoder: a scoreboard class predicts and checks subidentifiers.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SUBIDS    = 128;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_BYTES  = 2000;

    class subid_scoreboard;
        boid_pkg::result_t            expected_q[$];
        logic [boid_pkg::VALUE_W-1:0] acc;
        logic                         first;
        logic [boid_pkg::CNT_W-1:0]   count;
        logic                         ovf;
        int                           mismatches;
        int                           bytes_seen;
        int                           results_seen;
        int                           overflow_seen;
        int                           capacity_seen;

        function new();
            mismatches    = 0;
            bytes_seen    = 0;
            results_seen  = 0;
            overflow_seen = 0;
            capacity_seen = 0;
            restart();
        endfunction

        function void restart();
            acc   = '0;
            first = 1'b1;
            count = '0;
            ovf   = 1'b0;
        endfunction

        function void push_subid(logic [boid_pkg::VALUE_W-1:0] value,
                                 logic [boid_pkg::CNT_W-1:0] index,
                                 logic last, boid_pkg::err_t err);
            boid_pkg::result_t r;
            r.value = value;
            r.index = index[boid_pkg::INDEX_W-1:0];
            r.last  = last;
            r.err   = err;
            expected_q.push_back(r);
        endfunction

        function void close_subid(logic last);
            if (count >= NUM_SUBIDS)
            begin
                push_subid('0, '0, last, boid_pkg::ERR_CAPACITY);
            end
            else
            begin
                push_subid(acc, count, last,
                           ovf ? boid_pkg::ERR_OVERFLOW : boid_pkg::ERR_NONE);
                count++;
            end
            acc = '0;
            ovf = 1'b0;
        endfunction

        function void note_byte(logic [7:0] d, logic l);
            bytes_seen++;
            if (first)
            begin
                if (d < boid_pkg::ARC_SPAN)
                begin
                    push_subid(32'd0, 8'd0, 1'b0, boid_pkg::ERR_NONE);
                    push_subid({24'd0, d}, 8'd1, l, boid_pkg::ERR_NONE);
                end
                else if (d < 2 * boid_pkg::ARC_SPAN)
                begin
                    push_subid(32'd1, 8'd0, 1'b0, boid_pkg::ERR_NONE);
                    push_subid({24'd0, d - boid_pkg::ARC_SPAN}, 8'd1, l, boid_pkg::ERR_NONE);
                end
                else
                begin
                    push_subid(32'd2, 8'd0, 1'b0, boid_pkg::ERR_NONE);
                    push_subid({24'd0, 8'(d - 2 * boid_pkg::ARC_SPAN)}, 8'd1, l,
                               boid_pkg::ERR_NONE);
                end
                count = 8'd2;
                acc   = '0;
                ovf   = 1'b0;
                first = 1'b0;
                if (l)
                    restart();
            end
            else
            begin
                if (acc[boid_pkg::VALUE_W-1:boid_pkg::VALUE_W-boid_pkg::DIGIT_W] != '0)
                    ovf = 1'b1;
                acc = {acc[boid_pkg::VALUE_W-boid_pkg::DIGIT_W-1:0], d[boid_pkg::DIGIT_W-1:0]};
                if (l)
                begin
                    close_subid(1'b1);
                    restart();
                end
                else if (!d[boid_pkg::CONT_BIT])
                begin
                    close_subid(1'b0);
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_subid(logic [31:0] v, logic [6:0] i, logic l, logic [1:0] e);
            boid_pkg::result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value %0d index %0d", v, i));
                return;
            end
            want = expected_q.pop_front();
            if (want.err == boid_pkg::ERR_OVERFLOW)
                overflow_seen++;
            if (want.err == boid_pkg::ERR_CAPACITY)
                capacity_seen++;
            if (v !== want.value)
                report_mismatch($sformatf("subid_value %0d, expected %0d", v, want.value));
            if (i !== want.index)
                report_mismatch($sformatf("subid_index %0d, expected %0d", i, want.index));
            if (l !== want.last)
                report_mismatch($sformatf("last_subid %0d, expected %0d", l, want.last));
            if (e !== want.err)
                report_mismatch($sformatf("error_code %0d, expected %0d", e, want.err));
        endtask
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        byte_valid  = 1'b0;
    logic [7:0]  data_byte   = 8'd0;
    logic        last_byte   = 1'b0;
    logic        subid_stall = 1'b0;
    logic        byte_stall;
    logic        subid_valid;
    logic [31:0] subid_value;
    logic [6:0]  subid_index;
    logic        last_subid;
    logic [1:0]  error_code;

    int              send_idle_pct = 37;
    int              recv_idle_pct = 48;
    int              bytes_sent    = 0;
    int              idle_cycles   = 0;
    logic [7:0]      oid_bytes[$];
    subid_scoreboard board = new();

    ber_oid_decoder #(
        .MAX_SUBIDS(NUM_SUBIDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .subid_valid(subid_valid),
        .subid_stall(subid_stall),
        .subid_value(subid_value),
        .subid_index(subid_index),
        .last_subid(last_subid),
        .error_code(error_code)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        subid_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                board.note_byte(data_byte, last_byte);
            if (subid_valid && !subid_stall)
                board.check_subid(subid_value, subid_index, last_subid, error_code);
            if ((byte_valid && !byte_stall) || (subid_valid && !subid_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic l);
        if ($urandom_range(99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        byte_valid <= 1'b1;
        data_byte  <= d;
        last_byte  <= l;
        do
            @(posedge clk);
        while (!(byte_valid && !byte_stall));
        bytes_sent++;
    endtask

    task automatic send_queued();
        for (int k = 0; k < oid_bytes.size(); k++)
            send_byte(oid_bytes[k], k == oid_bytes.size() - 1);
        oid_bytes.delete();
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.expected_q.size() != 0);
        @(posedge clk);
    endtask

    function automatic void add_subid(input int octets);
        for (int j = 0; j < octets; j++)
            oid_bytes.push_back({(j < octets - 1) ? 1'b1 : 1'b0, 7'($urandom_range(127))});
    endfunction

    function automatic void build_identifier(input int n_sub);
        int octets;
        oid_bytes.push_back(8'($urandom_range(255)));
        repeat (n_sub)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: octets = $urandom_range(1, 2);
                6, 7:             octets = $urandom_range(3, 4);
                8:                octets = 5;
                default:          octets = 6;
            endcase
            add_subid(octets);
        end
        // An identifier that is cut short ends on a continuation octet.
        if ($urandom_range(9) == 0)
            oid_bytes.push_back(8'($urandom_range(128, 255)));
    endfunction

    initial
    begin
        int r;
        int target;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_byte(8'd0, 1'b1);
        send_byte(8'd39, 1'b1);
        send_byte(8'd40, 1'b1);
        send_byte(8'd79, 1'b1);
        send_byte(8'd80, 1'b1);
        send_byte(8'd255, 1'b1);
        oid_bytes = '{8'h2B, 8'h06, 8'h01, 8'h81, 8'h00};
        send_queued();
        oid_bytes = '{8'h2A, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        send_queued();
        oid_bytes = '{8'h2A, 8'h90, 8'h80, 8'h80, 8'h80, 8'h00, 8'h05};
        send_queued();
        oid_bytes = '{8'h2A, 8'h80, 8'h00, 8'h85};
        send_queued();
        drain();

        // Fill every index, then drop an overflowing subidentifier and a final one.
        oid_bytes = '{8'h2B};
        repeat (NUM_SUBIDS - 2) oid_bytes.push_back(8'($urandom_range(127)));
        oid_bytes.push_back(8'h90);
        oid_bytes.push_back(8'h80);
        oid_bytes.push_back(8'h80);
        oid_bytes.push_back(8'h80);
        oid_bytes.push_back(8'h00);
        oid_bytes.push_back(8'h7F);
        send_queued();

        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 37;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = bytes_sent + RANDOM_BYTES / 3;
            while (bytes_sent < target)
            begin
                r = $urandom_range(99);
                if (r < 5)
                begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                else
                begin
                    build_identifier((r == 99) ? $urandom_range(126, 132) : $urandom_range(0, 8));
                    send_queued();
                end
            end
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.expected_q.size() != 0)
            board.report_mismatch($sformatf("%0d expected results never arrived",
                                            board.expected_q.size()));

        $display("Run covered %0d octets and %0d subidentifiers under three idle patterns.",
                 board.bytes_seen, board.results_seen);
        $display("Subidentifiers with value overflow: %0d, dropped for capacity: %0d.",
                 board.overflow_seen, board.capacity_seen);
        if (board.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

`default_nettype wire
